// File: hdl/jtt_pkg.sv
package jtt_pkg;

  localparam int JOINT_COUNT = 6;
  localparam int JW = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
  localparam logic [23:0] DURATION_RESET = 24'd1000000;
  // (2^27 + 1) / 3, exact floor divide by three for values below 2^26
  localparam logic [25:0] RECIP3 = 26'd44739243;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_ABS  = 2'd1,
    OP_REL  = 2'd2,
    OP_LIM  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CMD,
    S_TLOAD,
    S_TDIV,
    S_TSQR,
    S_TREC,
    S_TMUL,
    S_TPOS,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic exec_cmd;
    logic tick_upd;
    logic div_step;
    logic sqr;
    logic rec;
    logic mul;
    logic pos_wb;
    logic jnext;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic op_tick;
    logic cur_act;
    logic reach;
    logic div_last;
    logic last_joint;
  } stat_t;

endpackage

// File: hdl/joint_trapezoid_trajectory.sv
// command or limit write: executed in S_CMD, then its result beat is offered in S_EMIT
// tick: per active joint S_TLOAD, S_TDIV (divider, one quotient bit a cycle), then S_TSQR,
//   S_TREC, S_TMUL and S_TPOS; an idle or finished joint only S_TLOAD; then one result beat per joint
// one item at a time: input is taken only when the previous result beats are gone
// rst (synchronous) clears all joint state and limits, move duration to 1000000 us
module joint_trapezoid_trajectory
  import jtt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // joint_index, value, value_high, limit_enable, tick_delta, zero pad
  input  logic [71:0] s_tdata,
  // opcode
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // joint_out, position, moving, all_idle, error, zero pad
  output logic [31:0] m_tdata,
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [23:0] cfg_data
);

  cmd_t  cmd;
  stat_t st;

  jtt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .st       (st),
    .cmd      (cmd)
  );

  jtt_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .st       (st),
    .in_op    (s_tuser),
    .in_data  (s_tdata[67:0]),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .out_data (m_tdata),
    .out_last (m_tlast)
  );

endmodule

// File: hdl/jtt_ctrl.sv
module jtt_ctrl
  import jtt_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  s_tvalid,
  output logic  s_tready,
  output logic  m_tvalid,
  input  logic  m_tready,
  input  stat_t st,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_CMD;
      end
      S_CMD: begin
        state_next = st.op_tick ? S_TLOAD : S_EMIT;
      end
      S_TLOAD: begin
        if (st.cur_act && !st.reach) state_next = S_TDIV;
        else if (st.last_joint) state_next = S_EMIT;
      end
      S_TDIV: begin
        if (st.div_last) state_next = S_TSQR;
      end
      S_TSQR: state_next = S_TREC;
      S_TREC: state_next = S_TMUL;
      S_TMUL: state_next = S_TPOS;
      S_TPOS: begin
        state_next = st.last_joint ? S_EMIT : S_TLOAD;
      end
      S_EMIT: begin
        if (m_tready && (!st.op_tick || st.last_joint)) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    s_tready = 1'b0;
    m_tvalid = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      S_CMD: cmd.exec_cmd = 1'b1;
      S_TLOAD: begin
        cmd.tick_upd = 1'b1;
        // skip to next joint when idle or finished, and wrap to zero for emit
        cmd.jnext = !(st.cur_act && !st.reach);
      end
      S_TDIV: cmd.div_step = 1'b1;
      S_TSQR: cmd.sqr = 1'b1;
      S_TREC: cmd.rec = 1'b1;
      S_TMUL: cmd.mul = 1'b1;
      S_TPOS: begin
        cmd.pos_wb = 1'b1;
        cmd.jnext = 1'b1;
      end
      S_EMIT: begin
        m_tvalid = 1'b1;
        cmd.emit = 1'b1;
        cmd.jnext = m_tready && st.op_tick;
      end
      default: ;
    endcase
  end

endmodule

// File: hdl/jtt_dp.sv
module jtt_dp
  import jtt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       st,
  input  logic [1:0]  in_op,
  input  logic [67:0] in_data,
  input  logic        cfg_we,
  input  logic [23:0] cfg_data,
  output logic [31:0] out_data,
  output logic        out_last
);

  logic signed [23:0] jpos   [JOINT_COUNT];
  logic signed [23:0] spos   [JOINT_COUNT];
  logic signed [23:0] tpos   [JOINT_COUNT];
  logic signed [23:0] lim_lo [JOINT_COUNT];
  logic signed [23:0] lim_hi [JOINT_COUNT];
  logic [31:0]        elap   [JOINT_COUNT];
  logic [23:0]        dur    [JOINT_COUNT];
  logic [JOINT_COUNT-1:0] act;
  logic [JOINT_COUNT-1:0] lim_on;

  logic [23:0] move_duration;
  op_t         op;
  logic [2:0]  idx;
  logic signed [23:0] val;
  logic signed [23:0] valh;
  logic        len;
  logic [15:0] dt;

  logic [JW-1:0] jcnt;
  logic [4:0]    dcnt;
  logic [23:0]   rem;
  logic [23:0]   quo;
  logic [45:0]   sq;
  logic [1:0]    region;
  logic [51:0]   prod3;
  logic signed [50:0] prodp;

  logic          bad;
  logic [JW-1:0] ji;
  logic signed [24:0] rsum;
  logic signed [23:0] tgt_raw;
  logic signed [23:0] tgt;
  logic [32:0]   esum;
  logic [31:0]   e_new;
  logic [24:0]   r2;
  logic [23:0]   tsel;
  logic [25:0]   nval;
  logic [26:0]   mid;
  logic [23:0]   q3;
  logic [24:0]   frac;
  logic signed [24:0] span;
  logic signed [50:0] rnd;

  assign bad = (4'(idx) >= 4'(JOINT_COUNT));
  assign ji  = idx[JW-1:0];

  // command target: relative sum saturates, then optional clamp
  always_comb begin
    rsum = 25'(jpos[ji]) + 25'(val);
    if (op == OP_REL) begin
      if (rsum < -25'sd8388608) tgt_raw = -24'sd8388608;
      else if (rsum > 25'sd8388607) tgt_raw = 24'sd8388607;
      else tgt_raw = rsum[23:0];
    end else begin
      tgt_raw = val;
    end
    tgt = tgt_raw;
    if (lim_on[ji]) begin
      if (tgt_raw < lim_lo[ji]) tgt = lim_lo[ji];
      else if (tgt_raw > lim_hi[ji]) tgt = lim_hi[ji];
    end
  end

  always_comb begin
    esum  = {1'b0, elap[jcnt]} + {17'd0, dt};
    e_new = esum[32] ? '1 : esum[31:0];
    r2    = {rem, 1'b0};
    // 2^24 - quo in 24 bits for the deceleration quarter
    tsel  = (quo < 24'h400000) ? quo : -quo;
    mid   = {quo, 3'b000} - 27'h1000000;
    nval  = (region == 2'd1) ? mid[26:1] : {2'b00, sq[44:21]};
    q3    = prod3[50:27];
    frac  = (region == 2'd2) ? (25'h1000000 - {1'b0, q3}) : {1'b0, q3};
    span  = 25'(tpos[jcnt]) - 25'(spos[jcnt]);
    rnd   = prodp + 51'sh800000;
  end

  assign st.op_tick    = (op == OP_TICK);
  assign st.cur_act    = act[jcnt];
  assign st.reach      = (e_new >= {8'd0, dur[jcnt]});
  assign st.div_last   = (dcnt == 5'd23);
  assign st.last_joint = (jcnt == JW'(JOINT_COUNT - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      move_duration <= DURATION_RESET;
      act    <= '0;
      lim_on <= '0;
      jcnt   <= '0;
      for (int i = 0; i < JOINT_COUNT; i++) begin
        jpos[i]   <= '0;
        spos[i]   <= '0;
        tpos[i]   <= '0;
        lim_lo[i] <= '0;
        lim_hi[i] <= '0;
        elap[i]   <= '0;
        dur[i]    <= '0;
      end
    end else begin
      if (cfg_we) move_duration <= cfg_data;
      if (cmd.load) begin
        op   <= op_t'(in_op);
        idx  <= in_data[2:0];
        val  <= in_data[26:3];
        valh <= in_data[50:27];
        len  <= in_data[51];
        dt   <= in_data[67:52];
        jcnt <= '0;
      end
      if (cmd.exec_cmd && !bad && op != OP_TICK) begin
        if (op == OP_LIM) begin
          lim_lo[ji] <= val;
          lim_hi[ji] <= valh;
          lim_on[ji] <= len;
        end else begin
          spos[ji] <= jpos[ji];
          tpos[ji] <= tgt;
          dur[ji]  <= move_duration;
          elap[ji] <= '0;
          act[ji]  <= (tgt != jpos[ji]);
        end
      end
      if (cmd.tick_upd && act[jcnt]) begin
        elap[jcnt] <= e_new;
        if (e_new >= {8'd0, dur[jcnt]}) begin
          jpos[jcnt] <= tpos[jcnt];
          act[jcnt]  <= 1'b0;
        end
        rem  <= e_new[23:0];
        dcnt <= '0;
      end
      if (cmd.div_step) begin
        if (r2 >= {1'b0, dur[jcnt]}) begin
          rem <= 24'(r2 - {1'b0, dur[jcnt]});
          quo <= {quo[22:0], 1'b1};
        end else begin
          rem <= r2[23:0];
          quo <= {quo[22:0], 1'b0};
        end
        dcnt <= dcnt + 5'd1;
      end
      if (cmd.sqr) begin
        sq <= 46'(tsel[22:0] * tsel[22:0]);
        if (quo < 24'h400000) region <= 2'd0;
        else if (quo < 24'hC00000) region <= 2'd1;
        else region <= 2'd2;
      end
      if (cmd.rec) prod3 <= nval * RECIP3;
      if (cmd.mul) prodp <= 51'(span * $signed({1'b0, frac}));
      if (cmd.pos_wb) jpos[jcnt] <= spos[jcnt] + rnd[47:24];
      if (cmd.jnext) jcnt <= st.last_joint ? '0 : jcnt + JW'(1);
    end
  end

  // result beat
  always_comb begin
    out_data = '0;
    out_last = 1'b1;
    if (op == OP_TICK) begin
      out_data[2:0]  = 3'(jcnt);
      out_data[26:3] = jpos[jcnt];
      out_data[27]   = act[jcnt];
      out_last       = st.last_joint;
    end else begin
      out_data[2:0] = idx;
      out_data[29]  = bad;
      if (!bad) begin
        out_data[26:3] = jpos[ji];
        out_data[27]   = act[ji];
      end
    end
    out_data[28] = ~|act;
  end

endmodule
